// ===== src/four_digit_decimal_calculator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-digit decimal calculator
// Clocked property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_DECIMAL_CALCULATOR_ASSERT_SVH
`define FOUR_DIGIT_DECIMAL_CALCULATOR_ASSERT_SVH

// Check a property on every edge outside reset.
`define FDDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define FDDC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== src/fddc_pkg.sv =====
// ----------------------------------------------------------------------------
// fddc_pkg
// Shared types and constants of the four-digit decimal calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package fddc_pkg;

   // key opcodes; code seven is unused and ignored
   localparam logic [2:0] OP_DIGIT = 3'd0;
   localparam logic [2:0] OP_CLEAR = 3'd1;
   localparam logic [2:0] OP_STORE = 3'd2;
   localparam logic [2:0] OP_ADD   = 3'd3;
   localparam logic [2:0] OP_SUB   = 3'd4;
   localparam logic [2:0] OP_MUL   = 3'd5;
   localparam logic [2:0] OP_DIV   = 3'd6;

   localparam logic [3:0] MAX_KEY     = 4'd9;
   localparam logic [3:0] BCD_LIMIT   = 4'd5;
   localparam logic [3:0] BCD_ADJUST  = 4'd3;
   localparam int         SHOW_DIGITS = 4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] key_digit;
   } req_type;

   typedef struct packed {
      logic [3:0] digit_thousands;
      logic [3:0] digit_hundreds;
      logic [3:0] digit_tens;
      logic [3:0] digit_ones;
      logic       negative_flag;
      logic       overflow_flag;
      logic       divide_error;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic exec;
      logic iter;
      logic conv;
      logic finish;
      logic send;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic iterate;
      logic convert;
   } sts_type;

endpackage

`default_nettype wire

// ===== src/four_digit_decimal_calculator.sv =====
// States each request passes through, by key:
//   digit, clear, store, ignored keys: evaluate, execute, send.
//   add, subtract, divide by zero: evaluate, execute, convert, finish, send.
//   multiply, divide: evaluate, execute, iterate, convert, finish, send.
// One request at a time; the next is taken once the result is
// registered. Reset is synchronous, active high, and clears all digits, operand, flags.
// ----------------------------------------------------------------------------
// four_digit_decimal_calculator
// Decimal keypad calculator: four entry digits, a stored first operand and
// add, subtract, multiply and divide with sign, overflow and divide flags.
// ----------------------------------------------------------------------------
`default_nettype none

module four_digit_decimal_calculator
   import fddc_pkg::*;
#(
   parameter int DIGITS = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // The controller walks each request through:
   //   evaluate - Horner pass over the entry, one digit per cycle, giving
   //              the entry in binary while rotating the digits back home
   //   execute  - apply digit, clear and store; seed add, subtract,
   //              multiply and divide
   //   iterate  - one shift-add or restoring-divide step per cycle
   //   convert  - double dabble, one magnitude bit per cycle, into twice
   //              as many decimal digits as the entry holds
   //   finish   - keep the low digits, flag overflow from the high ones
   //   send     - load the result register once it is free
   cmd_type cmd;
   sts_type sts;

   fddc_ctrl #(
      .DIGITS (DIGITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The result register sits in the datapath, so a finished result can
   // wait for the consumer while the next request is already accepted.
   fddc_dp #(
      .DIGITS (DIGITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

`include "four_digit_decimal_calculator_assert.svh"

   // only one request in flight
   `FDDC_ASSERT(a_single_request, (req_valid && req_ready) |=> !req_ready, "request overlap")
   // never overwrite a result still waiting
   `FDDC_ASSERT(a_no_overwrite, cmd.send |-> (!rsp_valid || rsp_ready), "result overwritten")
   // at most one datapath command per cycle
   `FDDC_ASSERT(a_one_command, $onehot0(cmd), "multiple commands")
   // reset leaves no result pending
   `FDDC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

`default_nettype wire

// ===== src/fddc_dp.sv =====
// ----------------------------------------------------------------------------
// fddc_dp
// Datapath: entry digits, first operand, shift-add multiply, restoring
// divide, double-dabble conversion and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fddc_dp
   import fddc_pkg::*;
#(
   parameter int DIGITS = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output rsp_type      rsp_data
);

   localparam int W     = $clog2(10 ** DIGITS);
   localparam int PW    = 2 * W;
   localparam int ND    = 2 * DIGITS;
   localparam int SHOWN = (DIGITS < SHOW_DIGITS) ? DIGITS : SHOW_DIGITS;

   logic [2:0]    op_ff, op_in;
   logic [3:0]    key_ff, key_in;
   logic [3:0]    entry_ff [DIGITS];
   logic [3:0]    entry_in [DIGITS];
   logic [W-1:0]  fop_ff, fop_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [PW-1:0] mag_ff, mag_in;
   logic [PW-1:0] mcand_ff, mcand_in;
   logic [3:0]    bcd_ff [ND];
   logic [3:0]    bcd_in [ND];
   logic [3:0]    adj [ND];
   logic          neg_ff, neg_in;
   logic          ovf_ff, ovf_in;
   logic          dve_ff, dve_in;
   rsp_type       rsp_ff, rsp_in;

   logic [W-1:0]  b_times_ten;
   logic [W:0]    rem_shift;
   logic [3:0]    disp [SHOW_DIGITS];
   logic          hi_nonzero;

   assign b_times_ten = {b_ff[W-4:0], 3'b000} + {b_ff[W-2:0], 1'b0};
   assign rem_shift   = {rem_ff, mag_ff[W-1]};

   assign sts.iterate = (op_ff == OP_MUL) || ((op_ff == OP_DIV) && (b_ff != '0));
   assign sts.convert = (op_ff == OP_ADD) || (op_ff == OP_SUB) ||
                        (op_ff == OP_MUL) || (op_ff == OP_DIV);

   always_comb begin
      for (int k = 0; k < ND; k++) begin
         adj[k] = (bcd_ff[k] >= BCD_LIMIT) ? bcd_ff[k] + BCD_ADJUST : bcd_ff[k];
      end
      hi_nonzero = 1'b0;
      for (int k = DIGITS; k < ND; k++) begin
         hi_nonzero = hi_nonzero | (bcd_ff[k] != 4'd0);
      end
      for (int j = 0; j < SHOW_DIGITS; j++) begin
         disp[j] = 4'd0;
      end
      for (int j = 0; j < SHOWN; j++) begin
         disp[j] = entry_ff[j];
      end
   end

   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      entry_in = entry_ff;
      fop_in   = fop_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      mag_in   = mag_ff;
      mcand_in = mcand_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      dve_in   = dve_ff;
      rsp_in   = rsp_ff;

      if (cmd.load) begin
         op_in  = req_data.opcode;
         key_in = req_data.key_digit;
         b_in   = '0;
      end

      // Horner step on the top digit; rotating DIGITS times restores the entry
      if (cmd.eval) begin
         b_in = b_times_ten + W'(entry_ff[DIGITS-1]);
         for (int i = 1; i < DIGITS; i++) begin
            entry_in[i] = entry_ff[i-1];
         end
         entry_in[0] = entry_ff[DIGITS-1];
      end

      if (cmd.exec) begin
         for (int k = 0; k < ND; k++) begin
            bcd_in[k] = 4'd0;
         end
         case (op_ff)
            OP_DIGIT: begin
               if (key_ff <= MAX_KEY) begin
                  for (int i = 1; i < DIGITS; i++) begin
                     entry_in[i] = entry_ff[i-1];
                  end
                  entry_in[0] = key_ff;
               end
            end
            OP_CLEAR: begin
               for (int i = 0; i < DIGITS; i++) begin
                  entry_in[i] = 4'd0;
               end
               fop_in = '0;
               neg_in = 1'b0;
               ovf_in = 1'b0;
               dve_in = 1'b0;
            end
            OP_STORE: begin
               for (int i = 0; i < DIGITS; i++) begin
                  entry_in[i] = 4'd0;
               end
               fop_in = b_ff;
               neg_in = 1'b0;
               ovf_in = 1'b0;
               dve_in = 1'b0;
            end
            OP_ADD: begin
               mag_in = PW'({1'b0, fop_ff} + {1'b0, b_ff});
               neg_in = 1'b0;
               ovf_in = 1'b0;
               dve_in = 1'b0;
            end
            OP_SUB: begin
               ovf_in = 1'b0;
               dve_in = 1'b0;
               if (fop_ff < b_ff) begin
                  mag_in = PW'(b_ff - fop_ff);
                  neg_in = 1'b1;
               end else begin
                  mag_in = PW'(fop_ff - b_ff);
                  neg_in = 1'b0;
               end
            end
            OP_MUL: begin
               mag_in   = '0;
               mcand_in = PW'(fop_ff);
               neg_in   = 1'b0;
               ovf_in   = 1'b0;
               dve_in   = 1'b0;
            end
            OP_DIV: begin
               neg_in = 1'b0;
               ovf_in = 1'b0;
               rem_in = '0;
               if (b_ff == '0) begin
                  mag_in = '0;
                  dve_in = 1'b1;
               end else begin
                  mag_in = PW'(fop_ff);
                  dve_in = 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (cmd.iter) begin
         if (op_ff == OP_MUL) begin
            if (b_ff[0]) begin
               mag_in = mag_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[PW-2:0], 1'b0};
            b_in     = {1'b0, b_ff[W-1:1]};
         end else begin
            // restoring divide: quotient bits shift into the low word of mag
            if (rem_shift >= {1'b0, b_ff}) begin
               rem_in = W'(rem_shift - {1'b0, b_ff});
               mag_in = PW'({mag_ff[W-2:0], 1'b1});
            end else begin
               rem_in = W'(rem_shift);
               mag_in = PW'({mag_ff[W-2:0], 1'b0});
            end
         end
      end

      // double dabble: adjust every digit, then shift one bit in
      if (cmd.conv) begin
         bcd_in[0] = {adj[0][2:0], mag_ff[PW-1]};
         for (int k = 1; k < ND; k++) begin
            bcd_in[k] = {adj[k][2:0], adj[k-1][3]};
         end
         mag_in = {mag_ff[PW-2:0], 1'b0};
      end

      if (cmd.finish) begin
         for (int i = 0; i < DIGITS; i++) begin
            entry_in[i] = bcd_ff[i];
         end
         ovf_in = hi_nonzero;
      end

      if (cmd.send) begin
         rsp_in.digit_thousands = disp[3];
         rsp_in.digit_hundreds  = disp[2];
         rsp_in.digit_tens      = disp[1];
         rsp_in.digit_ones      = disp[0];
         rsp_in.negative_flag   = neg_ff;
         rsp_in.overflow_flag   = ovf_ff;
         rsp_in.divide_error    = dve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGITS; i++) begin
            entry_ff[i] <= 4'd0;
         end
         fop_ff <= '0;
         neg_ff <= 1'b0;
         ovf_ff <= 1'b0;
         dve_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         fop_ff   <= fop_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         dve_ff   <= dve_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      mag_ff   <= mag_in;
      mcand_ff <= mcand_in;
      bcd_ff   <= bcd_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== src/fddc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fddc_ctrl
// Controller: sequences one request through evaluate, execute, iterate,
// convert, finish and send, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fddc_ctrl
   import fddc_pkg::*;
#(
   parameter int DIGITS = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam int W  = $clog2(10 ** DIGITS);
   localparam int PW = 2 * W;
   localparam int CW = $clog2(PW);

   localparam logic [CW-1:0] LAST_EVAL = CW'(DIGITS - 1);
   localparam logic [CW-1:0] LAST_ITER = CW'(W - 1);
   localparam logic [CW-1:0] LAST_CONV = CW'(PW - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EVAL   = 7'b0000010,
      ST_EXEC   = 7'b0000100,
      ST_ITER   = 7'b0001000,
      ST_CONV   = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_SEND   = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (cnt_ff == LAST_EVAL) begin
               cnt_in   = '0;
               state_in = ST_EXEC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in   = '0;
            if (sts.iterate) begin
               state_in = ST_ITER;
            end else if (sts.convert) begin
               state_in = ST_CONV;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            if (cnt_ff == LAST_ITER) begin
               cnt_in   = '0;
               state_in = ST_CONV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (cnt_ff == LAST_CONV) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.send) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
